// ----- rtl/core/pa2al_pkg.sv -----
// ----------------------------------------------------------------------------
// pa2al_pkg
// Shared types, constants and helpers for the PA-II active learner.
// ----------------------------------------------------------------------------
package pa2al_pkg;

	localparam int WEIGHT_COUNT = 1024;
	localparam int MAX_NONZEROS = 64;
	localparam int WADDR_W      = $clog2(WEIGHT_COUNT);
	localparam int BADDR_W      = $clog2(MAX_NONZEROS);
	localparam int CNT_W        = $clog2(MAX_NONZEROS + 1);
	localparam int DIV_STEPS    = 32;
	localparam int STEP_W       = $clog2(DIV_STEPS + 1);
	localparam int PADDR_W      = 3;

	typedef enum logic [1:0] {
		KIND_FEATURE = 2'd0,
		KIND_END     = 2'd1,
		KIND_READ    = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	localparam logic REG_QUERY_SCALE = 1'b0;
	localparam logic REG_HALF_INV_C  = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FEAT_MUL,
		ST_FEAT_ACC,
		ST_END_SCORE,
		ST_END_QMUL,
		ST_END_QCMP,
		ST_DIV,
		ST_WALK_BUF,
		ST_WALK_W,
		ST_WALK_MUL,
		ST_WALK_WR,
		ST_RESULT
	} state_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_CLEAR,
		OP_CAPTURE,
		OP_FEAT_MUL,
		OP_FEAT_ACC,
		OP_END_SCORE,
		OP_END_QMUL,
		OP_END_QCMP,
		OP_DIV,
		OP_WALK_BUF,
		OP_WALK_W,
		OP_WALK_MUL,
		OP_WALK_WR,
		OP_LOAD
	} dp_op_t;

	typedef struct packed {
		logic clr_last;
		logic buf_full;
		logic buf_empty;
		logic do_update;
		logic div_done;
		logic walk_last;
	} dp_status_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v, input logic c);
		sat_inc = (c && v != 32'hFFFF_FFFF) ? v + 32'd1 : v;
	endfunction

endpackage

// ----- rtl/core/pa2al_ctrl.sv -----
// ----------------------------------------------------------------------------
// pa2al_ctrl
// Sequencer: steps the datapath through feature, end, divide and update walk.
// ----------------------------------------------------------------------------
module pa2al_ctrl import pa2al_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_kind,
	output logic       in_ready,
	input  logic       out_ready,
	output logic       out_valid,
	input  dp_status_t status,
	output dp_op_t     op
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:     if (status.clr_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_valid) begin
					unique case (kind_t'(in_kind))
						KIND_FEATURE: state_d = status.buf_full ? ST_IDLE : ST_FEAT_MUL;
						KIND_END:     state_d = ST_END_SCORE;
						KIND_READ:    state_d = ST_RESULT;
						KIND_NONE:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_FEAT_MUL:  state_d = ST_FEAT_ACC;
			ST_FEAT_ACC:  state_d = ST_IDLE;
			ST_END_SCORE: state_d = ST_END_QMUL;
			ST_END_QMUL:  state_d = ST_END_QCMP;
			ST_END_QCMP:  state_d = status.do_update ? ST_DIV : ST_RESULT;
			ST_DIV: begin
				if (status.div_done) state_d = status.buf_empty ? ST_RESULT : ST_WALK_BUF;
			end
			ST_WALK_BUF:  state_d = ST_WALK_W;
			ST_WALK_W:    state_d = ST_WALK_MUL;
			ST_WALK_MUL:  state_d = ST_WALK_WR;
			ST_WALK_WR:   state_d = status.walk_last ? ST_RESULT : ST_WALK_BUF;
			ST_RESULT:    if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		op = OP_NOP;
		unique case (state_q)
			ST_CLEAR:     op = OP_CLEAR;
			ST_IDLE:      if (in_valid) op = OP_CAPTURE;
			ST_FEAT_MUL:  op = OP_FEAT_MUL;
			ST_FEAT_ACC:  op = OP_FEAT_ACC;
			ST_END_SCORE: op = OP_END_SCORE;
			ST_END_QMUL:  op = OP_END_QMUL;
			ST_END_QCMP:  op = OP_END_QCMP;
			ST_DIV:       op = OP_DIV;
			ST_WALK_BUF:  op = OP_WALK_BUF;
			ST_WALK_W:    op = OP_WALK_W;
			ST_WALK_MUL:  op = OP_WALK_MUL;
			ST_WALK_WR:   op = OP_WALK_WR;
			ST_RESULT:    if (out_free) op = OP_LOAD;
			default:      op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (op == OP_LOAD)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/core/pa2al_dp.sv -----
// ----------------------------------------------------------------------------
// pa2al_dp
// Datapath: weight memory, nonzero buffer, accumulators, divider, counters.
// ----------------------------------------------------------------------------
module pa2al_dp import pa2al_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_op_t              op,
	output dp_status_t          status,
	input  logic [1:0]          kind,
	input  logic [9:0]          feature_index,
	input  logic signed [23:0]  feature_value,
	input  logic                label_positive,
	input  logic [15:0]         random_draw,
	input  logic [31:0]         query_scale,
	input  logic [31:0]         half_inverse_c,
	output logic signed [47:0]  score,
	output logic                predicted_positive,
	output logic                queried,
	output logic                updated,
	output logic                overflow,
	output logic [31:0]         correct_count,
	output logic [31:0]         predicted_pos_count,
	output logic [31:0]         actual_pos_count,
	output logic [31:0]         true_pos_count,
	output logic [31:0]         query_count,
	output logic signed [31:0]  weight_value
);

	// weight memory
	logic signed [31:0] wmem [WEIGHT_COUNT];
	logic signed [31:0] w_rdata_q;
	logic [WADDR_W-1:0] w_raddr, w_waddr;
	logic signed [31:0] w_wdata;
	logic               w_re, w_we;

	// nonzero buffer
	logic [9:0]         bidx_mem [MAX_NONZEROS];
	logic signed [23:0] bval_mem [MAX_NONZEROS];
	logic [9:0]         bidx_rd_q;
	logic signed [23:0] bval_rd_q;

	// captured item
	logic [9:0]         idx_q;
	logic signed [23:0] x_q;
	logic               y_q, read_q;
	logic [15:0]        draw_q;

	// instance state
	logic signed [63:0] dot_q;
	logic [63:0]        norm_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               ovf_flag_q;
	logic [31:0]        stats_q [5];
	logic [WADDR_W-1:0] clr_q;

	// feature products
	logic signed [55:0] prod_s1;
	logic signed [47:0] sq_s1;

	// end-of-instance
	logic signed [47:0] score_q;
	logic               pred_q, queried_q, upd_q, ovf_res_q, ys_low_q;
	logic [64:0]        qprod_q;
	logic [63:0]        d_q, margin_q;

	// divider
	logic [63:0]        rem_q;
	logic [31:0]        quo_q;
	logic [STEP_W-1:0]  step_q;
	logic               tsat_q;
	logic [31:0]        tau;

	// walk
	logic [CNT_W-1:0]   walk_q;
	logic signed [56:0] wprod_s1;

	// combinational
	logic signed [64:0] dot_sum;
	logic signed [63:0] dot_next;
	logic [47:0]        mag;
	logic [48:0]        bm;
	logic signed [48:0] ys;
	logic               q_now, due, dz;
	logic [64:0]        r2;
	logic signed [57:0] adj;
	logic signed [41:0] delta;
	logic signed [42:0] nw;
	logic signed [31:0] nw_sat;

	assign tau = tsat_q ? 32'hFFFF_FFFF : quo_q;

	always_comb begin
		dot_sum  = {dot_q[63], dot_q} + 65'(prod_s1);
		dot_next = dot_sum[63:0];
		if (dot_sum[64] != dot_sum[63])
			dot_next = dot_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
	end

	always_comb begin
		mag   = score_q[47] ? 48'(-score_q) : 48'(score_q);
		bm    = {17'd0, query_scale} + {1'b0, mag};
		ys    = y_q ? 49'(score_q) : -49'(score_q);
		q_now = qprod_q <= {17'd0, query_scale, 16'd0};
		due   = q_now && ys_low_q;
		dz    = (d_q == 64'd0);
		r2    = {rem_q, 1'b0};
	end

	always_comb begin
		adj    = y_q ? 58'(wprod_s1) : -58'(wprod_s1);
		delta  = 42'(adj >>> 16);
		nw     = 43'(w_rdata_q) + 43'(delta);
		nw_sat = nw[31:0];
		if (nw > 43'sd2147483647)       nw_sat = 32'sh7FFF_FFFF;
		else if (nw < -43'sd2147483648) nw_sat = 32'sh8000_0000;
	end

	always_comb begin
		status.clr_last  = (clr_q == WADDR_W'(WEIGHT_COUNT - 1));
		status.buf_full  = (cnt_q == CNT_W'(MAX_NONZEROS));
		status.buf_empty = (cnt_q == '0);
		status.do_update = due && !dz && !ovf_flag_q;
		status.div_done  = tsat_q || (step_q == STEP_W'(DIV_STEPS));
		status.walk_last = ((walk_q + CNT_W'(1)) == cnt_q);
	end

	// weight memory ports
	always_comb begin
		w_re    = (op == OP_CAPTURE) || (op == OP_WALK_W);
		w_raddr = (op == OP_CAPTURE) ? feature_index[WADDR_W-1:0] : bidx_rd_q[WADDR_W-1:0];
		w_we    = (op == OP_CLEAR) || (op == OP_WALK_WR);
		w_waddr = (op == OP_CLEAR) ? clr_q : bidx_rd_q[WADDR_W-1:0];
		w_wdata = (op == OP_CLEAR) ? 32'sd0 : nw_sat;
	end

	always_ff @(posedge clk) begin
		if (w_we) wmem[w_waddr] <= w_wdata;
		if (w_re) w_rdata_q <= wmem[w_raddr];
	end

	always_ff @(posedge clk) begin
		if (op == OP_FEAT_MUL) begin
			bidx_mem[cnt_q[BADDR_W-1:0]] <= idx_q;
			bval_mem[cnt_q[BADDR_W-1:0]] <= x_q;
		end
		if (op == OP_WALK_BUF) begin
			bidx_rd_q <= bidx_mem[walk_q[BADDR_W-1:0]];
			bval_rd_q <= bval_mem[walk_q[BADDR_W-1:0]];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (op)
			OP_CAPTURE: begin
				idx_q  <= feature_index;
				x_q    <= feature_value;
				y_q    <= label_positive;
				draw_q <= random_draw;
				read_q <= (kind_t'(kind) == KIND_READ);
			end
			OP_FEAT_MUL: begin
				prod_s1 <= 56'(w_rdata_q) * 56'(x_q);
				sq_s1   <= 48'(x_q) * 48'(x_q);
			end
			OP_END_SCORE: begin
				score_q <= dot_q[63:16];
				pred_q  <= !dot_q[63] && (dot_q[63:16] != 48'd0);
			end
			OP_END_QMUL: begin
				qprod_q  <= {49'd0, draw_q} * {16'd0, bm};
				d_q      <= norm_q + {16'd0, half_inverse_c, 16'd0};
				ys_low_q <= ys < 49'sd65536;
				margin_q <= 64'(49'sd65536 - ys);
			end
			OP_END_QCMP: begin
				queried_q <= q_now;
				upd_q     <= due && !dz && !ovf_flag_q;
				ovf_res_q <= ovf_flag_q || (due && dz);
				rem_q     <= margin_q;
				quo_q     <= '0;
				tsat_q    <= margin_q >= d_q;
			end
			OP_DIV: begin
				if (!(tsat_q || step_q == STEP_W'(DIV_STEPS))) begin
					if (r2 >= {1'b0, d_q}) begin
						rem_q <= 64'(r2 - {1'b0, d_q});
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= r2[63:0];
						quo_q <= {quo_q[30:0], 1'b0};
					end
				end
			end
			OP_WALK_MUL: wprod_s1 <= 57'(signed'({1'b0, tau})) * 57'(bval_rd_q);
			OP_LOAD: begin
				score              <= read_q ? 48'sd0 : score_q;
				predicted_positive <= !read_q && pred_q;
				queried            <= !read_q && queried_q;
				updated            <= !read_q && upd_q;
				overflow           <= !read_q && ovf_res_q;
				weight_value       <= read_q ? w_rdata_q : 32'sd0;
				correct_count       <= stats_q[0];
				predicted_pos_count <= stats_q[1];
				actual_pos_count    <= stats_q[2];
				true_pos_count      <= stats_q[3];
				query_count         <= stats_q[4];
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q      <= '0;
			norm_q     <= '0;
			cnt_q      <= '0;
			ovf_flag_q <= 1'b0;
			clr_q      <= '0;
			step_q     <= '0;
			walk_q     <= '0;
			for (int i = 0; i < 5; i++) stats_q[i] <= '0;
		end else begin
			unique case (op)
				OP_CLEAR: clr_q <= clr_q + WADDR_W'(1);
				OP_CAPTURE: begin
					if (kind_t'(kind) == KIND_FEATURE && status.buf_full) ovf_flag_q <= 1'b1;
				end
				OP_FEAT_MUL: cnt_q <= cnt_q + CNT_W'(1);
				OP_FEAT_ACC: begin
					dot_q  <= dot_next;
					norm_q <= norm_q + {16'd0, sq_s1};
				end
				OP_END_QCMP: begin
					stats_q[0] <= sat_inc(stats_q[0], pred_q == y_q);
					stats_q[1] <= sat_inc(stats_q[1], pred_q);
					stats_q[2] <= sat_inc(stats_q[2], y_q);
					stats_q[3] <= sat_inc(stats_q[3], pred_q && y_q);
					stats_q[4] <= sat_inc(stats_q[4], q_now);
					step_q     <= '0;
					walk_q     <= '0;
				end
				OP_DIV: begin
					if (!status.div_done) step_q <= step_q + STEP_W'(1);
				end
				OP_WALK_WR: walk_q <= walk_q + CNT_W'(1);
				OP_LOAD: begin
					if (!read_q) begin
						dot_q      <= '0;
						norm_q     <= '0;
						cnt_q      <= '0;
						ovf_flag_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/core/pa2_active_learner_update.sv -----
// ----------------------------------------------------------------------------
// pa2_active_learner_update
// Online sparse PA-II classifier with randomised label query.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake          | Carries
//  in       | input     | in_valid/in_ready  | kind, index, value, label, draw
//  out      | output    | out_valid/out_ready| score, flags, counters, weight
//  config   | input     | APB psel/penable   | query_scale, half_inverse_c
//
//  Feature transfer: memory read, multiply, accumulate.
//  Read transfer: weight read plus output wait. End transfer: score, query multiply
//  and compare, then the bit-serial tau divider (cut short when tau saturates) and,
//  when an update is due, a buffer read, weight read, multiply and write per nonzero.
//  After reset a clearing pass zeroes all 1024 weight memory words, in_ready
//  held low. A stalled result holds in the output register; the next item is
//  taken, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module pa2_active_learner_update import pa2al_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          kind,
	input  logic [9:0]          feature_index,
	input  logic signed [23:0]  feature_value,
	input  logic                label_positive,
	input  logic [15:0]         random_draw,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [47:0]  score,
	output logic                predicted_positive,
	output logic                queried,
	output logic                updated,
	output logic                overflow,
	output logic [31:0]         correct_count,
	output logic [31:0]         predicted_pos_count,
	output logic [31:0]         actual_pos_count,
	output logic [31:0]         true_pos_count,
	output logic [31:0]         query_count,
	output logic signed [31:0]  weight_value
);

	logic [31:0] query_scale_q, half_inv_c_q;
	logic        cfg_wr;
	dp_op_t      op;
	dp_status_t  status;

	// config: write in the access phase; pready tied high
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_scale_q <= 32'h0001_0000;
			half_inv_c_q  <= 32'h0000_8000;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_QUERY_SCALE: query_scale_q <= pwdata;
				REG_HALF_INV_C:  half_inv_c_q  <= pwdata;
			endcase
		end
	end

	always_comb begin
		prdata = 32'd0;
		unique case (paddr[2])
			REG_QUERY_SCALE: prdata = query_scale_q;
			REG_HALF_INV_C:  prdata = half_inv_c_q;
		endcase
	end

	// sequencer: one op per cycle to the datapath
	pa2al_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_kind   (kind),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.status    (status),
		.op        (op)
	);

	// datapath: weights, buffer, accumulators, divider, counters, result register
	pa2al_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.op                  (op),
		.status              (status),
		.kind                (kind),
		.feature_index       (feature_index),
		.feature_value       (feature_value),
		.label_positive      (label_positive),
		.random_draw         (random_draw),
		.query_scale         (query_scale_q),
		.half_inverse_c      (half_inv_c_q),
		.score               (score),
		.predicted_positive  (predicted_positive),
		.queried             (queried),
		.updated             (updated),
		.overflow            (overflow),
		.correct_count       (correct_count),
		.predicted_pos_count (predicted_pos_count),
		.actual_pos_count    (actual_pos_count),
		.true_pos_count      (true_pos_count),
		.query_count         (query_count),
		.weight_value        (weight_value)
	);

	// an update only follows a query on a clean instance
	a_upd_needs_query: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && updated |-> queried && !overflow)
		else $error("update without query or with overflow");

	// positive prediction means a strictly positive score
	a_pred_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && predicted_positive |-> !score[47] && score != 48'sd0)
		else $error("prediction disagrees with score");

	// end-of-instance results carry no weight
	a_end_no_weight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (queried || predicted_positive) |-> weight_value == 32'sd0)
		else $error("weight on end-of-instance result");

	// no new item is taken while the weight memory clears or work is in flight
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready || $past(kind) == KIND_NONE
			|| $past(status.buf_full))
		else $error("item taken while busy");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PA-II active learner. A queue of stream items
// (feature entries, end-of-instance, weight reads, ignored kinds) feeds a
// randomly paced driver. An in-bench model of the weight store, instance
// buffer, counters and tau divider predicts every result. A randomly stalling
// monitor compares each result field by field. Both registers are swept over
// several settings between drained phases.
// ----------------------------------------------------------------------------
module tb_top;
	import pa2al_pkg::*;

	typedef struct {
		kind_t              kind;
		logic [9:0]         idx;
		logic signed [23:0] val;
		logic               lab;
		logic [15:0]        draw;
	} lrn_item_t;

	typedef struct {
		logic signed [47:0] score;
		logic               pred;
		logic               qry;
		logic               upd;
		logic               ovf;
		logic [31:0]        stats [5];
		logic signed [31:0] weight;
	} lrn_result_t;

	localparam longint SCORE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SCORE_MIN = -64'sh0000_8000_0000_0000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel, penable, pwrite, pready;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata, prdata;
	logic               in_valid, in_ready, out_valid, out_ready;
	logic [1:0]         kind;
	logic [9:0]         feature_index;
	logic signed [23:0] feature_value;
	logic               label_positive;
	logic [15:0]        random_draw;
	logic signed [47:0] score;
	logic               predicted_positive, queried, updated, overflow;
	logic [31:0]        correct_count, predicted_pos_count, actual_pos_count;
	logic [31:0]        true_pos_count, query_count;
	logic signed [31:0] weight_value;

	pa2_active_learner_update dut (.*);

	always #1 clk = ~clk;

	// learner model state
	logic signed [31:0] mdl_weights [WEIGHT_COUNT];
	logic [9:0]         mdl_buf_idx [MAX_NONZEROS];
	logic signed [23:0] mdl_buf_val [MAX_NONZEROS];
	int                 mdl_entries;
	longint             mdl_dot;
	longint unsigned    mdl_norm;
	bit                 mdl_ovf;
	logic [31:0]        mdl_stats [5];
	logic [31:0]        mdl_qscale, mdl_hinv;

	lrn_item_t   stream_items [$];
	lrn_result_t score_reports [$];
	lrn_item_t   cur_item;
	int          snd_gap, rcv_gap, phase_items, errors;
	bit          no_idle;

	function automatic int pace();
		return no_idle ? 0 : $urandom_range(0, 16);
	endfunction

	function automatic longint sat_add(input longint a, input longint b);
		longint s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63])
			return a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		return s;
	endfunction

	function automatic void bump(input int i, input bit c);
		if (c && mdl_stats[i] != 32'hFFFF_FFFF)
			mdl_stats[i] = mdl_stats[i] + 32'd1;
	endfunction

	// tau = floor(margin * 2^32 / d), saturated to 32 bits
	function automatic logic [31:0] tau_of(input longint unsigned margin,
			input longint unsigned d);
		logic [127:0] quo;
		quo = {32'b0, margin, 32'b0} / {64'b0, d};
		return (quo > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
	endfunction

	// Advance the model by one accepted transfer; queue any result it causes
	task automatic learn_item(input lrn_item_t it);
		lrn_result_t     r;
		longint          sc, ys, prod, nw, t;
		longint unsigned mag, margin, d;
		logic [79:0]     lhs, rhs;
		logic [31:0]     tau;
		bit              y;
		case (it.kind)
			KIND_FEATURE: begin
				if (mdl_entries < MAX_NONZEROS) begin
					mdl_buf_idx[mdl_entries] = it.idx;
					mdl_buf_val[mdl_entries] = it.val;
					mdl_dot = sat_add(mdl_dot, longint'(mdl_weights[it.idx]) * longint'(it.val));
					mdl_norm = mdl_norm + longint'(it.val) * longint'(it.val);
					mdl_entries++;
				end else begin
					mdl_ovf = 1'b1;
				end
			end
			KIND_NONE: ;
			default: begin
				r.score = '0; r.pred = 0; r.qry = 0; r.upd = 0; r.ovf = 0; r.weight = '0;
				if (it.kind == KIND_READ) begin
					r.weight = mdl_weights[it.idx];
				end else begin
					y = it.lab;
					sc = mdl_dot >>> 16;
					if (sc > SCORE_MAX) sc = SCORE_MAX;
					if (sc < SCORE_MIN) sc = SCORE_MIN;
					r.score = sc[47:0];
					r.pred = sc > 0;
					r.ovf = mdl_ovf;
					bump(0, r.pred == y);
					bump(1, r.pred);
					bump(2, y);
					bump(3, r.pred && y);
					mag = (sc < 0) ? -sc : sc;
					lhs = {64'b0, it.draw} * ({48'b0, mdl_qscale} + {16'b0, mag});
					rhs = {48'b0, mdl_qscale} << 16;
					r.qry = lhs <= rhs;
					bump(4, r.qry);
					ys = y ? sc : -sc;
					if (r.qry && ys < 65536) begin
						margin = 65536 - ys;
						d = mdl_norm + ({32'b0, mdl_hinv} << 16);
						if (d == 0) begin
							r.ovf = 1'b1;
						end else if (!mdl_ovf) begin
							tau = tau_of(margin, d);
							t = {32'b0, tau};
							// apply in buffer order; repeated indices stack
							for (int i = 0; i < mdl_entries; i++) begin
								prod = t * longint'(mdl_buf_val[i]);
								if (!y) prod = -prod;
								nw = longint'(mdl_weights[mdl_buf_idx[i]]) + (prod >>> 16);
								if (nw > 64'sh7FFF_FFFF) nw = 64'sh7FFF_FFFF;
								if (nw < -64'sh8000_0000) nw = -64'sh8000_0000;
								mdl_weights[mdl_buf_idx[i]] = nw[31:0];
							end
							r.upd = 1'b1;
						end
					end
					mdl_entries = 0;
					mdl_dot = 0;
					mdl_norm = 0;
					mdl_ovf = 0;
				end
				r.stats = mdl_stats;
				score_reports.push_back(r);
			end
		endcase
	endtask

	// Sender: hold each item until its transfer, then idle for a drawn gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			snd_gap = 0;
		end else begin
			if (in_valid && in_ready)
				learn_item(cur_item);
			if (!in_valid || in_ready) begin
				if (snd_gap > 0) begin
					snd_gap--;
					in_valid <= 1'b0;
				end else if (stream_items.size() > 0) begin
					cur_item = stream_items.pop_front();
					kind <= cur_item.kind;
					feature_index <= cur_item.idx;
					feature_value <= cur_item.val;
					label_positive <= cur_item.lab;
					random_draw <= cur_item.draw;
					in_valid <= 1'b1;
					snd_gap = pace();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic field_chk(input string nm, input logic [63:0] e, input logic [63:0] a);
		if (e !== a) begin
			$error("%s: expected %0h, got %0h", nm, e, a);
			errors++;
		end
	endtask

	// Receiver: check each result transfer, then stall for a drawn count
	always @(posedge clk or negedge arst_n) begin
		lrn_result_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rcv_gap = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (score_reports.size() == 0) begin
					$error("result transfer with nothing expected");
					errors++;
				end else begin
					e = score_reports.pop_front();
					field_chk("score", 64'(e.score), 64'(score));
					field_chk("predicted_positive", 64'(e.pred), 64'(predicted_positive));
					field_chk("queried", 64'(e.qry), 64'(queried));
					field_chk("updated", 64'(e.upd), 64'(updated));
					field_chk("overflow", 64'(e.ovf), 64'(overflow));
					field_chk("correct_count", 64'(e.stats[0]), 64'(correct_count));
					field_chk("predicted_pos_count", 64'(e.stats[1]),
						64'(predicted_pos_count));
					field_chk("actual_pos_count", 64'(e.stats[2]), 64'(actual_pos_count));
					field_chk("true_pos_count", 64'(e.stats[3]), 64'(true_pos_count));
					field_chk("query_count", 64'(e.stats[4]), 64'(query_count));
					field_chk("weight_value", 64'(e.weight), 64'(weight_value));
				end
				rcv_gap = pace();
			end
			if (rcv_gap > 0) begin
				rcv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic add_item(input kind_t k, input logic [9:0] i, input logic signed [23:0] v,
			input logic l, input logic [15:0] d);
		lrn_item_t it;
		it.kind = k; it.idx = i; it.val = v; it.lab = l; it.draw = d;
		stream_items.push_back(it);
		phase_items++;
	endtask

	task automatic wr_reg(input logic sel, input logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (sel == REG_QUERY_SCALE) mdl_qscale = v;
		else mdl_hinv = v;
	endtask

	// Wait for every transfer and result, then idle before the next phase
	task automatic drain();
		while (stream_items.size() > 0 || in_valid || score_reports.size() > 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic rand_instance();
		int r, nf;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			add_item(KIND_READ, 10'($urandom_range(0, 1023)), 24'($urandom),
				1'($urandom), 16'($urandom));
		end else if (r < 10) begin
			add_item(KIND_NONE, 10'($urandom), 24'($urandom), 1'($urandom), 16'($urandom));
		end else begin
			// an occasional instance overruns the nonzero buffer
			nf = (r < 12) ? MAX_NONZEROS + $urandom_range(1, 4) : $urandom_range(0, 12);
			for (int i = 0; i < nf; i++)
				add_item(KIND_FEATURE,
					($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15)),
					$signed(24'($urandom)) >>> $urandom_range(0, 22), 1'($urandom),
					16'($urandom));
			add_item(KIND_END, 10'($urandom), 24'($urandom), 1'($urandom),
				($urandom_range(0, 9) < 3) ? 16'd0 : 16'($urandom));
		end
	endtask

	initial begin
		logic [31:0] qs [4];
		logic [31:0] hi [4];
		qs = '{32'd65536, 32'd0, 32'hFFFF_FFFF, 32'd0};
		hi = '{32'd32768, 32'd0, 32'hFFFF_FFFF, 32'd0};
		qs[3] = $urandom_range(1, 32'h0004_0000);
		hi[3] = $urandom_range(1, 32'h0001_0000);
		arst_n = 1'b0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		kind = '0; feature_index = '0; feature_value = '0;
		label_positive = 0; random_draw = '0;
		errors = 0;
		no_idle = 0;
		foreach (mdl_weights[i]) mdl_weights[i] = '0;
		foreach (mdl_stats[i]) mdl_stats[i] = '0;
		mdl_entries = 0; mdl_dot = 0; mdl_norm = 0; mdl_ovf = 0;
		mdl_qscale = 32'd65536; mdl_hinv = 32'd32768;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < 4; p++) begin
			wr_reg(REG_QUERY_SCALE, qs[p]);
			wr_reg(REG_HALF_INV_C, hi[p]);
			phase_items = 0;
			if (p == 0) begin
				// fresh store, extreme indices and values, certain query
				add_item(KIND_READ, 10'd0, '0, 0, '0);
				add_item(KIND_READ, 10'd1023, '0, 0, '0);
				add_item(KIND_FEATURE, 10'd1023, 24'sh7FFFFF, 1, 16'hFFFF);
				add_item(KIND_FEATURE, 10'd0, -24'sh800000, 0, 16'h0);
				add_item(KIND_FEATURE, 10'd1023, 24'sh000001, 0, 16'h0);
				add_item(KIND_END, 10'd0, '0, 1, 16'd0);
				add_item(KIND_READ, 10'd1023, '0, 0, '0);
				add_item(KIND_READ, 10'd0, '0, 0, '0);
				add_item(KIND_NONE, 10'h3FF, 24'hFFFFFF, 1, 16'hFFFF);
				// empty instance: update runs with nothing to change
				add_item(KIND_END, 10'h3FF, 24'hFFFFFF, 0, 16'hFFFF);
				add_item(KIND_FEATURE, 10'd5, 24'sh000001, 0, 16'h0);
				add_item(KIND_END, 10'd0, '0, 0, 16'h8000);
				add_item(KIND_FEATURE, 10'd1023, 24'sh7FFFFF, 1, 16'h0);
				add_item(KIND_END, 10'd0, '0, 1, 16'hFFFF);
			end else if (p == 1) begin
				// zero scale with zero score queries; zero divisor flags overflow
				add_item(KIND_END, 10'd0, '0, 1, 16'hFFFF);
				add_item(KIND_END, 10'd0, '0, 0, 16'h1234);
				add_item(KIND_FEATURE, 10'd900, -24'sh000100, 1, 16'h0);
				add_item(KIND_END, 10'd0, '0, 0, 16'd0);
			end
			while (phase_items < 480) begin
				if ($urandom_range(0, 19) == 0) no_idle = !no_idle;
				rand_instance();
			end
			// hold the sender until every result has come back
			drain();
		end
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#3000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
